### rtl/core/qclt_pkg.sv
// Package for the quoted command line tokenizer.
// Holds shared constants, the result record type and a character helper.
// No dependencies.
package qclt_pkg;

  // Default limits, handed to the top level's parameters
  localparam int unsigned TokenLimitDef       = 128;
  localparam int unsigned TokenLengthLimitDef = 255;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Special characters
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  // One result request as carried from front to back
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic [6:0] token_index;
    logic [7:0] byte_index;
    logic       token_end;
    logic       line_done;
    logic [7:0] token_total;
    logic       truncated;
    logic       tokens_dropped;
  } qclt_rec_t;

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

### rtl/core/qclt_front.sv
// Front part of the tokenizer: accepts characters, tracks quote, escape
// and token state, and builds result requests. Depends on qclt_pkg.
module qclt_front import qclt_pkg::*; #(
  parameter int unsigned TOKEN_LIMIT        = TokenLimitDef,
  parameter int unsigned TOKEN_LENGTH_LIMIT = TokenLengthLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_line_i,
  input  logic       q_full_i,
  output logic       push_o,
  output qclt_rec_t  rec_o
);

  localparam int unsigned CntW = $clog2(TOKEN_LIMIT + 1);
  localparam int unsigned BcW  = $clog2(TOKEN_LENGTH_LIMIT + 1);

  logic            in_token_q, in_token_d;
  logic            squote_q, squote_d;
  logic            dquote_q, dquote_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] tok_cnt_q, tok_cnt_d;
  logic [BcW-1:0]  bc_q, bc_d;
  logic            trunc_q, trunc_d;
  logic            drop_q, drop_d;

  logic accept;
  logic has_res;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_res;

  always_comb begin
    logic            dropping;
    logic            do_emit;
    logic [BcW-1:0]  bc_eff;
    logic [CntW-1:0] cnt_inc;
    dropping = tok_cnt_q >= CntW'(TOKEN_LIMIT);
    do_emit  = 1'b0;
    bc_eff   = bc_q;
    cnt_inc  = CntW'(tok_cnt_q + 1'b1);

    in_token_d = in_token_q;
    squote_d   = squote_q;
    dquote_d   = dquote_q;
    esc_d      = esc_q;
    tok_cnt_d  = tok_cnt_q;
    bc_d       = bc_q;
    trunc_d    = trunc_q;
    drop_d     = drop_q;
    has_res    = 1'b0;
    rec_o      = '0;
    rec_o.token_total    = 8'(tok_cnt_q);
    rec_o.truncated      = trunc_q;
    rec_o.tokens_dropped = drop_q;

    if (end_of_line_i || (char_byte_i == ChNul)) begin
      has_res         = 1'b1;
      rec_o.line_done = 1'b1;
      if (in_token_q && !dropping) begin
        rec_o.token_end   = 1'b1;
        rec_o.token_index = 7'(tok_cnt_q);
        rec_o.byte_index  = 8'(bc_q);
        rec_o.token_total = 8'(cnt_inc);
      end
      in_token_d = 1'b0;
      squote_d   = 1'b0;
      dquote_d   = 1'b0;
      esc_d      = 1'b0;
      tok_cnt_d  = '0;
      bc_d       = '0;
      trunc_d    = 1'b0;
      drop_d     = 1'b0;
    end else if (esc_q) begin
      esc_d   = 1'b0;
      do_emit = 1'b1;
    end else if (in_token_q || !is_blank(char_byte_i)) begin
      if (!in_token_q) begin
        in_token_d = 1'b1;
        bc_eff     = '0;
        bc_d       = '0;
        if (dropping) drop_d = 1'b1;
      end
      if ((char_byte_i == ChSquote) && !dquote_q) begin
        squote_d = !squote_q;
      end else if ((char_byte_i == ChDquote) && !squote_q) begin
        dquote_d = !dquote_q;
      end else if (char_byte_i == ChBslash) begin
        esc_d = 1'b1;
      end else if (is_blank(char_byte_i) && !squote_q && !dquote_q) begin
        in_token_d = 1'b0;
        bc_d       = '0;
        if (!dropping) begin
          has_res           = 1'b1;
          rec_o.token_end   = 1'b1;
          rec_o.token_index = 7'(tok_cnt_q);
          rec_o.byte_index  = 8'(bc_eff);
          rec_o.token_total = 8'(cnt_inc);
          tok_cnt_d         = cnt_inc;
        end
      end else begin
        do_emit = 1'b1;
      end
    end

    if (do_emit && !dropping) begin
      if (bc_eff >= BcW'(TOKEN_LENGTH_LIMIT)) begin
        trunc_d = 1'b1;
      end else begin
        has_res           = 1'b1;
        rec_o.out_byte    = char_byte_i;
        rec_o.is_data     = 1'b1;
        rec_o.token_index = 7'(tok_cnt_q);
        rec_o.byte_index  = 8'(bc_eff);
        bc_d              = BcW'(bc_eff + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_token_q <= 1'b0;
      squote_q   <= 1'b0;
      dquote_q   <= 1'b0;
      esc_q      <= 1'b0;
      tok_cnt_q  <= '0;
      bc_q       <= '0;
      trunc_q    <= 1'b0;
      drop_q     <= 1'b0;
    end else if (accept) begin
      in_token_q <= in_token_d;
      squote_q   <= squote_d;
      dquote_q   <= dquote_d;
      esc_q      <= esc_d;
      tok_cnt_q  <= tok_cnt_d;
      bc_q       <= bc_d;
      trunc_q    <= trunc_d;
      drop_q     <= drop_d;
    end
  end

endmodule

### rtl/core/qclt_queue.sv
// Short queue of result requests between front and back.
// Depends on qclt_pkg.
module qclt_queue import qclt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  qclt_rec_t push_rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output qclt_rec_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  qclt_rec_t       slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !do_pop) cnt_d = CntW'(cnt_q + 1'b1);
    else if (!push_i && do_pop) cnt_d = CntW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_rec_i;
  end

endmodule

### rtl/core/qclt_back.sv
// Back part of the tokenizer: pulls result requests from the queue into
// the output register and hands them out. Depends on qclt_pkg.
module qclt_back import qclt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  qclt_rec_t q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output qclt_rec_t out_rec_o
);

  logic      out_valid_q, out_valid_d;
  qclt_rec_t out_rec_q;
  logic      load;

  // Register is free when empty or being taken this cycle
  assign load        = !out_valid_q || out_ready_i;
  assign q_pop_o     = load && q_valid_i;
  assign out_valid_d = load ? q_valid_i : out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) out_rec_q <= q_head_i;
  end

endmodule

### rtl/core/quoted_command_line_tokenizer.sv
// Quoted command line tokenizer, top level: one character request in, at most
// one result request out. Each result passes through the queue and then the
// output register before it is offered. Throughput 1 character per cycle while
// the 2-entry queue behind the front is not full; the front stalls when it is.
// Reset (rst_ni, async, active low) clears all token, quote and flag state
// and empties the queue and output register. Depends on qclt_pkg.
module quoted_command_line_tokenizer import qclt_pkg::*; #(
  parameter int unsigned TOKEN_LIMIT        = TokenLimitDef,
  parameter int unsigned TOKEN_LENGTH_LIMIT = TokenLengthLimitDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_line_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic [6:0] token_index_o,
  output logic [7:0] byte_index_o,
  output logic       token_end_o,
  output logic       line_done_o,
  output logic [7:0] token_total_o,
  output logic       truncated_o,
  output logic       tokens_dropped_o
);

  // Front -> queue
  logic      push;
  qclt_rec_t push_rec;
  logic      q_full;
  // Queue -> back
  logic      q_valid;
  logic      q_pop;
  qclt_rec_t q_head;
  qclt_rec_t out_rec;

  // Front: classifies each character and updates the token state in the
  // cycle it is accepted. Stalls only when the queue is full.
  qclt_front #(
    .TOKEN_LIMIT       (TOKEN_LIMIT),
    .TOKEN_LENGTH_LIMIT(TOKEN_LENGTH_LIMIT)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .char_byte_i,
    .end_of_line_i,
    .q_full_i (q_full),
    .push_o   (push),
    .rec_o    (push_rec)
  );

  // Queue decouples the front from downstream back-pressure
  qclt_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Back: output register, refilled in the cycle it is taken
  qclt_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_rec_o   (out_rec)
  );

  assign out_byte_o       = out_rec.out_byte;
  assign is_data_o        = out_rec.is_data;
  assign token_index_o    = out_rec.token_index;
  assign byte_index_o     = out_rec.byte_index;
  assign token_end_o      = out_rec.token_end;
  assign line_done_o      = out_rec.line_done;
  assign token_total_o    = out_rec.token_total;
  assign truncated_o      = out_rec.truncated;
  assign tokens_dropped_o = out_rec.tokens_dropped;

endmodule

### rtl/core/qclt_checker.sv
// Port-level checks for the tokenizer, bound to the top level.
// Depends on quoted_command_line_tokenizer port names only.
module qclt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] char_byte_i,
  input logic       end_of_line_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_data_o,
  input logic [6:0] token_index_o,
  input logic [7:0] byte_index_o,
  input logic       token_end_o,
  input logic       line_done_o,
  input logic [7:0] token_total_o,
  input logic       truncated_o,
  input logic       tokens_dropped_o
);

  // Stalled request stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(char_byte_i)
      && $stable(end_of_line_i))
    else $error("input request changed while stalled");

  // Stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(token_index_o) && $stable(byte_index_o) && $stable(token_end_o)
      && $stable(line_done_o) && $stable(is_data_o) && $stable(token_total_o)
      && $stable(truncated_o) && $stable(tokens_dropped_o))
    else $error("output request changed while stalled");

  // Data results never close a token or a line
  a_data_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_data_o |-> !token_end_o && !line_done_o)
    else $error("data result marked as token or line end");

  // Non-data results carry a zero byte
  a_mark_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> out_byte_o == 8'h00)
    else $error("non-data result carries a byte");

  // A line end that closes no token reports zero indexes
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o && !token_end_o |-> token_index_o == 7'd0
      && byte_index_o == 8'd0)
    else $error("bare line end with non-zero index");

endmodule

bind quoted_command_line_tokenizer qclt_checker u_qclt_checker (.*);
